// ----- sv/three_phase_voltage_modulator_macros.svh -----
// Assertion macros shared by the three-phase voltage modulator RTL.
`ifndef THREE_PHASE_VOLTAGE_MODULATOR_MACROS_SVH
`define THREE_PHASE_VOLTAGE_MODULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPVM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpvm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPVM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpvm assertion failed");

`endif

// ----- sv/tpvm_pkg.sv -----
// Package with the types, codes, constants and tables of the voltage modulator.
`default_nettype none
package tpvm_pkg;

    typedef enum logic [1:0] {
        MODE_TRAP120 = 2'd0,
        MODE_TRAP150 = 2'd1,
        MODE_SINE    = 2'd2,
        MODE_SVM     = 2'd3
    } mode_t;

    localparam logic [2:0] REG_MODULATION_MODE   = 3'd0;
    localparam logic [2:0] REG_ZERO_ANGLE_OFFSET = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_LIMIT     = 3'd2;
    localparam logic [2:0] REG_SUPPLY_VOLTAGE    = 3'd3;
    localparam logic [2:0] REG_PWM_PERIOD        = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int PHASE_W     = 40;

    localparam logic [16:0] SQRT3_Q16      = 17'd113512;
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

    localparam logic signed [1:0] TP = 2'sb01;
    localparam logic signed [1:0] TN = 2'sb11;
    localparam logic signed [1:0] TZ = 2'sb00;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] offset;
        logic [14:0] limit;
        logic [14:0] supply;
        logic [15:0] period;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         sector;
        logic signed [15:0] uq;
        logic signed [15:0] ud;
    } item_head_t;

    typedef struct packed {
        logic signed [1:0] a;
        logic signed [1:0] b;
        logic signed [1:0] c;
    } trap_coef_t;

    function automatic trap_coef_t trap_coef(input mode_t mode, input logic [3:0] sector);
        trap_coef_t r;
        r = '{TZ, TZ, TZ};
        if (mode == MODE_TRAP120) begin
            case (sector)
                4'd0: r = '{TZ, TP, TN};
                4'd1: r = '{TN, TP, TZ};
                4'd2: r = '{TN, TZ, TP};
                4'd3: r = '{TZ, TN, TP};
                4'd4: r = '{TP, TN, TZ};
                4'd5: r = '{TP, TZ, TN};
                default: r = '{TZ, TZ, TZ};
            endcase
        end else begin
            case (sector)
                4'd0:  r = '{TZ, TP, TN};
                4'd1:  r = '{TN, TP, TN};
                4'd2:  r = '{TN, TP, TZ};
                4'd3:  r = '{TN, TP, TP};
                4'd4:  r = '{TN, TZ, TP};
                4'd5:  r = '{TN, TN, TP};
                4'd6:  r = '{TZ, TN, TP};
                4'd7:  r = '{TP, TN, TP};
                4'd8:  r = '{TP, TN, TZ};
                4'd9:  r = '{TP, TN, TN};
                4'd10: r = '{TP, TZ, TN};
                4'd11: r = '{TP, TP, TN};
                default: r = '{TZ, TZ, TZ};
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/tpvm_front.sv -----
// Front end: wraps the angle and classifies a command into sector and angle residue.
`default_nettype none
module tpvm_front #(
    parameter int ANGLE_BITS = 16
) (
    input  tpvm_pkg::cfg_t          cfg,
    input  logic signed [15:0]      uq_in,
    input  logic signed [15:0]      ud_in,
    input  logic [15:0]             electrical_angle,
    output tpvm_pkg::item_head_t    head,
    output logic [ANGLE_BITS-1:0]   ang
);
    import tpvm_pkg::*;

    localparam int AW = ANGLE_BITS;
    localparam logic [AW-1:0] HALF_TURN    = AW'(1) << (AW - 1);
    localparam logic [AW-1:0] QUARTER_TURN = AW'(1) << (AW - 2);

    logic [16:0]   ang_sum;
    logic [AW-1:0] p;
    logic [AW-1:0] p_svm;
    logic [AW+2:0] t6;
    logic [AW+2:0] t6s;
    logic [AW+3:0] t12;
    logic [2:0]    s6;
    logic [3:0]    s12;

    assign ang_sum = {1'b0, electrical_angle} + {1'b0, cfg.offset};
    assign p       = AW'(ang_sum);
    assign t6      = (AW+3)'(p) * (AW+3)'(6) + (AW+3)'(HALF_TURN);
    assign s6      = t6[AW+2:AW];
    assign t12     = (AW+4)'(p) * (AW+4)'(12);
    assign s12     = t12[AW+3:AW] + 4'd1;
    assign p_svm   = p + (uq_in[15] ? HALF_TURN : '0) + QUARTER_TURN;
    assign t6s     = (AW+3)'(p_svm) * (AW+3)'(6);

    always_comb begin
        head.mode = cfg.mode;
        head.uq   = uq_in;
        head.ud   = ud_in;
        ang       = p;
        case (cfg.mode)
            MODE_TRAP120: head.sector = (s6 == 3'd6) ? 4'd0 : {1'b0, s6};
            MODE_TRAP150: head.sector = (s12 == 4'd12) ? 4'd0 : s12;
            MODE_SINE:    head.sector = 4'd0;
            MODE_SVM: begin
                head.sector = {1'b0, t6s[AW+2:AW]} + 4'd1;
                ang         = t6s[AW-1:0];
            end
            default:      head.sector = 4'd0;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/tpvm_queue.sv -----
// Short queue of classified commands between the front end and the back end.
`default_nettype none
`include "three_phase_voltage_modulator_macros.svh"
module tpvm_queue #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tpvm_pkg::item_head_t    push_head,
    input  logic [ANGLE_BITS-1:0]   push_ang,
    output logic                    full,
    input  logic                    pop,
    output logic                    empty,
    output tpvm_pkg::item_head_t    pop_head,
    output logic [ANGLE_BITS-1:0]   pop_ang
);
    import tpvm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_head_t            head_mem [QUEUE_DEPTH];
    logic [ANGLE_BITS-1:0] ang_mem  [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_head = head_mem[rd_ptr_reg];
    assign pop_ang  = ang_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            head_mem[wr_ptr_reg] <= push_head;
            ang_mem[wr_ptr_reg]  <= push_ang;
        end
    end

    `TPVM_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `TPVM_ASSERT_NXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule
`default_nettype wire

// ----- sv/tpvm_sine.sv -----
// Four-stage pipelined quarter-wave sine polynomial in Q15.
`default_nettype none
module tpvm_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        z_in,
    input  logic               neg_in,
    output logic signed [17:0] sin_out
);
    logic [15:0] z_a_reg, z2_a_reg, z_b_reg, z2_b_reg, z_c_reg, t0_c_reg;
    logic [14:0] w_b_reg;
    logic        neg_a_reg, neg_b_reg, neg_c_reg;
    logic [31:0] zz;
    logic [27:0] m1;
    logic [30:0] m2;
    logic [31:0] m3;
    logic [16:0] t;

    assign zz = 32'(z_in) * 32'(z_in);
    assign m1 = 28'(z2_a_reg) * 28'd2320;
    assign m2 = 31'(z2_b_reg) * 31'(w_b_reg);
    assign m3 = 32'(z_c_reg) * 32'(t0_c_reg);
    assign t  = 17'(m3 >> 15);

    always_ff @(posedge aclk) begin
        if (en) begin
            z_a_reg   <= z_in;
            neg_a_reg <= neg_in;
            z2_a_reg  <= zz[30:15];
            z_b_reg   <= z_a_reg;
            z2_b_reg  <= z2_a_reg;
            neg_b_reg <= neg_a_reg;
            w_b_reg   <= 15'd21024 - 15'(m1 >> 15);
            z_c_reg   <= z_b_reg;
            neg_c_reg <= neg_b_reg;
            t0_c_reg  <= 16'(17'd51472 - 17'(m2 >> 15));
            sin_out   <= neg_c_reg ? -$signed({1'b0, t}) : $signed({1'b0, t});
        end
    end

endmodule
`default_nettype wire

// ----- sv/tpvm_duty.sv -----
// Per-phase duty stage: clamp, scale by the period and a pipelined divide by the supply.
`default_nettype none
module tpvm_duty #(
    parameter int PWM_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  tpvm_pkg::cfg_t                       cfg,
    input  logic signed [tpvm_pkg::PHASE_W-1:0]  u_in,
    output logic [15:0]                          compare
);
    import tpvm_pkg::*;

    localparam int PW = PWM_BITS;
    localparam int NW = 31 + PW;

    logic [30:0]   lim_full;
    logic [30:0]   dvs;
    logic [30:0]   uc;
    logic          sat;
    logic          dz;
    logic [PW-1:0] period;
    logic [PW-1:0] res;
    logic [NW-1:0] num_reg;
    logic [30:0]   rem_reg [PW];
    logic [PW-1:0] low_reg [PW];
    logic [PW-1:0] q_reg   [PW];
    logic          sat_reg [PW+1];

    assign lim_full = {cfg.limit, 16'b0};
    assign dvs      = {cfg.supply, 16'b0};
    assign period   = cfg.period[PW-1:0];
    assign dz       = (cfg.supply == '0);

    always_comb begin
        if (u_in < 0) begin
            uc = '0;
        end else if (u_in > $signed(PHASE_W'(lim_full))) begin
            uc = lim_full;
        end else begin
            uc = 31'(u_in);
        end
        sat = (uc != '0) && (uc >= dvs);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= NW'(uc) * NW'(period);
            sat_reg[0] <= sat;
        end
    end

    for (genvar j = 0; j < PW; j++) begin : g_div
        logic [30:0]   r_in;
        logic [31:0]   r_sh;
        logic [PW-1:0] l_in;
        logic [PW-1:0] q_in;
        logic          ge;
        if (j == 0) begin : g_first
            assign r_in = num_reg[NW-1:PW];
            assign l_in = num_reg[PW-1:0];
            assign q_in = '0;
        end else begin : g_next
            assign r_in = rem_reg[j-1];
            assign l_in = low_reg[j-1];
            assign q_in = q_reg[j-1];
        end
        assign r_sh = {r_in, l_in[PW-1]};
        assign ge   = (r_sh >= {1'b0, dvs});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]   <= 31'(ge ? r_sh - {1'b0, dvs} : r_sh);
                low_reg[j]   <= l_in << 1;
                q_reg[j]     <= PW'({q_in, ge});
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    assign res     = sat_reg[PW] ? period : (dz ? '0 : q_reg[PW-1]);
    assign compare = 16'(res);

endmodule
`default_nettype wire

// ----- sv/tpvm_back.sv -----
// Back end: sine, transforms, phase voltages and duty pipeline with output register.
`default_nettype none
`include "three_phase_voltage_modulator_macros.svh"
module tpvm_back #(
    parameter int ANGLE_BITS = 16,
    parameter int PWM_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tpvm_pkg::cfg_t         cfg,
    input  logic                   q_empty,
    input  tpvm_pkg::item_head_t   q_head,
    input  logic [ANGLE_BITS-1:0]  q_ang,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            compare_a,
    output logic [15:0]            compare_b,
    output logic [15:0]            compare_c,
    output logic [3:0]             sector_number
);
    import tpvm_pkg::*;

    localparam int AW = ANGLE_BITS;
    localparam int L  = 10 + PWM_BITS;
    localparam logic [AW-1:0] QUARTER_TURN = AW'(1) << (AW - 2);
    localparam logic [AW:0]   FULL_TURN    = (AW+1)'(1) << AW;

    typedef struct packed {
        item_head_t  head;
        logic [15:0] mag;
    } ctx_t;

    function automatic logic [16:0] z_quarter(input logic [AW-1:0] x);
        logic [AW+12:0] zf;
        logic [15:0]    z;
        zf = {x[AW-3:0], 15'b0} >> (AW - 2);
        z  = 16'(zf);
        if (x[AW-2]) begin
            z = 16'd32768 - z;
        end
        return {x[AW-1], z};
    endfunction

    function automatic logic [15:0] z_sixth(input logic [AW:0] x);
        logic [AW+16:0] yw;
        logic [16:0]    y;
        logic [33:0]    pr;
        yw = {x, 16'b0} >> AW;
        y  = 17'(yw);
        pr = 34'(y) * 34'd43691;
        return 16'(pr >> 17);
    endfunction

    function automatic logic signed [PHASE_W-1:0] trap_term(
        input logic signed [1:0] k, input logic signed [15:0] uq);
        logic signed [PHASE_W-1:0] v;
        v = PHASE_W'(uq) <<< 16;
        case (k)
            TP:      return v;
            TN:      return -v;
            default: return '0;
        endcase
    endfunction

    logic [L-1:0] valid_reg;
    logic         adv;
    ctx_t         ctx_in;
    ctx_t         ctx_reg [L];
    logic [16:0]  uq17;

    logic [15:0] za, zb, za_reg, zb_reg;
    logic        nega, negb, nega_reg, negb_reg;
    logic signed [17:0] sin_a, sin_b;

    logic signed [33:0] p_cu_reg, p_su_reg, p_sd_reg, p_cq_reg;
    logic [32:0]        m1_reg, m2_reg;
    logic signed [35:0] al_reg, be_reg, al8_reg;
    logic [49:0]        m1x_reg, m2x_reg;
    logic signed [52:0] k_reg;
    logic [34:0]        v1_reg, v2_reg;
    logic signed [PHASE_W-1:0] ua, ub, uc, ua_reg, ub_reg, uc_reg;

    assign adv      = !valid_reg[L-1] || m_tready;
    assign q_pop    = adv && !q_empty;
    assign m_tvalid = valid_reg[L-1];
    assign uq17     = {q_head.uq[15], q_head.uq};

    always_comb begin
        ctx_in.head = q_head;
        ctx_in.mag  = uq17[16] ? 16'(-uq17) : 16'(uq17);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[L-2:0], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx_reg[0] <= ctx_in;
            for (int i = 1; i < L; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    always_comb begin
        if (q_head.mode == MODE_SVM) begin
            za   = z_sixth(FULL_TURN - {1'b0, q_ang});
            zb   = z_sixth({1'b0, q_ang});
            nega = 1'b0;
            negb = 1'b0;
        end else begin
            {nega, za} = z_quarter(q_ang);
            {negb, zb} = z_quarter(q_ang + QUARTER_TURN);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            za_reg   <= za;
            zb_reg   <= zb;
            nega_reg <= nega;
            negb_reg <= negb;
        end
    end

    tpvm_sine u_sin_a (
        .aclk    (aclk),
        .en      (adv),
        .z_in    (za_reg),
        .neg_in  (nega_reg),
        .sin_out (sin_a)
    );

    tpvm_sine u_sin_b (
        .aclk    (aclk),
        .en      (adv),
        .z_in    (zb_reg),
        .neg_in  (negb_reg),
        .sin_out (sin_b)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_cu_reg <= sin_b * ctx_reg[4].head.ud;
            p_su_reg <= sin_a * ctx_reg[4].head.uq;
            p_sd_reg <= sin_a * ctx_reg[4].head.ud;
            p_cq_reg <= sin_b * ctx_reg[4].head.uq;
            m1_reg   <= 33'(ctx_reg[4].mag) * 33'(sin_a[16:0]);
            m2_reg   <= 33'(ctx_reg[4].mag) * 33'(sin_b[16:0]);

            al_reg   <= (36'(p_cu_reg) - 36'(p_su_reg)) <<< 1;
            be_reg   <= (36'(p_sd_reg) + 36'(p_cq_reg)) <<< 1;
            m1x_reg  <= 50'(m1_reg) * 50'(SQRT3_Q16);
            m2x_reg  <= 50'(m2_reg) * 50'(SQRT3_Q16);

            k_reg    <= be_reg * $signed(SQRT3_HALF_Q16);
            al8_reg  <= al_reg;
            v1_reg   <= 35'(m1x_reg >> 15);
            v2_reg   <= 35'(m2x_reg >> 15);

            ua_reg   <= ua;
            ub_reg   <= ub;
            uc_reg   <= uc;
        end
    end

    always_comb begin
        logic signed [PHASE_W-1:0] half_s, lim16, v1s, v2s, h;
        logic signed [53:0]        al_sh, sb, sc;
        trap_coef_t                tc;
        half_s = $signed(PHASE_W'({cfg.limit, 15'b0}));
        lim16  = $signed(PHASE_W'({cfg.limit, 16'b0}));
        v1s    = $signed(PHASE_W'(v1_reg));
        v2s    = $signed(PHASE_W'(v2_reg));
        h      = (lim16 - v1s - v2s) >>> 1;
        al_sh  = 54'(al8_reg) <<< 15;
        sb     = 54'(k_reg) - al_sh;
        sc     = -al_sh - 54'(k_reg);
        tc     = trap_coef(ctx_reg[7].head.mode, ctx_reg[7].head.sector);
        case (ctx_reg[7].head.mode)
            MODE_SINE: begin
                ua = PHASE_W'(al8_reg) + half_s;
                ub = PHASE_W'(sb >>> 16) + half_s;
                uc = PHASE_W'(sc >>> 16) + half_s;
            end
            MODE_SVM: begin
                case (ctx_reg[7].head.sector)
                    4'd1: begin
                        ua = v1s + v2s + h; ub = v2s + h; uc = h;
                    end
                    4'd2: begin
                        ua = v1s + h; ub = v1s + v2s + h; uc = h;
                    end
                    4'd3: begin
                        ua = h; ub = v1s + v2s + h; uc = v2s + h;
                    end
                    4'd4: begin
                        ua = h; ub = v1s + h; uc = v1s + v2s + h;
                    end
                    4'd5: begin
                        ua = v2s + h; ub = h; uc = v1s + v2s + h;
                    end
                    default: begin
                        ua = v1s + v2s + h; ub = h; uc = v1s + h;
                    end
                endcase
            end
            default: begin
                ua = trap_term(tc.a, ctx_reg[7].head.uq) + half_s;
                ub = trap_term(tc.b, ctx_reg[7].head.uq) + half_s;
                uc = trap_term(tc.c, ctx_reg[7].head.uq) + half_s;
            end
        endcase
    end

    tpvm_duty #(.PWM_BITS(PWM_BITS)) u_duty_a (
        .aclk    (aclk),
        .en      (adv),
        .cfg     (cfg),
        .u_in    (ua_reg),
        .compare (compare_a)
    );

    tpvm_duty #(.PWM_BITS(PWM_BITS)) u_duty_b (
        .aclk    (aclk),
        .en      (adv),
        .cfg     (cfg),
        .u_in    (ub_reg),
        .compare (compare_b)
    );

    tpvm_duty #(.PWM_BITS(PWM_BITS)) u_duty_c (
        .aclk    (aclk),
        .en      (adv),
        .cfg     (cfg),
        .u_in    (uc_reg),
        .compare (compare_c)
    );

    assign sector_number = ctx_reg[L-1].head.sector;

    `TPVM_ASSERT_NXT(a_hold_on_stall, aclk, aresetn, !adv, $stable(valid_reg))
    `TPVM_ASSERT_IMP(a_svm_sector, aclk, aresetn, m_tvalid && (ctx_reg[L-1].head.mode == MODE_SVM), (sector_number >= 4'd1) && (sector_number <= 4'd6))

endmodule
`default_nettype wire

// ----- sv/three_phase_voltage_modulator.sv -----
// Top level of the three-phase voltage modulator with its configuration registers.
// The block takes one command transaction per clock cycle while the queue is not full
// and returns one result transaction for each, in order. A combinational front end
// wraps the angle and finds the sector, a four-entry queue holds classified commands,
// and the back end is a single pipeline that advances whenever its output register is
// empty or being taken. An accepted command passes through the queue, one stage that
// registers the polynomial inputs, four sine polynomial stages, four transform and
// phase stages, one scaling multiply and one stage per compare bit of the restoring
// divider by the supply voltage.
// Configuration writes take effect on the next cycle.
`default_nettype none
module three_phase_voltage_modulator #(
    parameter int ANGLE_BITS = 16,
    parameter int PWM_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // q voltage [15:0], d voltage [31:16], electrical_angle [47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // compare_a [15:0], compare_b [31:16], compare_c [47:32], sector_number [51:48]
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import tpvm_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    item_head_t            f_head;
    item_head_t            q_head;
    logic [ANGLE_BITS-1:0] f_ang;
    logic [ANGLE_BITS-1:0] q_ang;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  push;
    logic [15:0]           compare_a, compare_b, compare_c;
    logic [3:0]            sector_number;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_MODULATION_MODE:   cfg_next.mode   = mode_t'(cfg_wdata[1:0]);
                REG_ZERO_ANGLE_OFFSET: cfg_next.offset = cfg_wdata;
                REG_VOLTAGE_LIMIT:     cfg_next.limit  = cfg_wdata[14:0];
                REG_SUPPLY_VOLTAGE:    cfg_next.supply = cfg_wdata[14:0];
                REG_PWM_PERIOD:        cfg_next.period = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: MODE_SVM, offset: 16'd0, limit: 15'd1536,
                         supply: 15'd3072, period: 16'd4095};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    tpvm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .cfg              (cfg_reg),
        .uq_in            (s_tdata[15:0]),
        .ud_in            (s_tdata[31:16]),
        .electrical_angle (s_tdata[47:32]),
        .head             (f_head),
        .ang              (f_ang)
    );

    tpvm_queue #(.ANGLE_BITS(ANGLE_BITS)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_head (f_head),
        .push_ang  (f_ang),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_head  (q_head),
        .pop_ang   (q_ang)
    );

    tpvm_back #(.ANGLE_BITS(ANGLE_BITS), .PWM_BITS(PWM_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_ang         (q_ang),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .compare_a     (compare_a),
        .compare_b     (compare_b),
        .compare_c     (compare_c),
        .sector_number (sector_number)
    );

    assign m_tdata = {4'b0, sector_number, compare_c, compare_b, compare_a};

endmodule
`default_nettype wire
